/* sv/aes_pkg.sv */
// ----------------------------------------------------------------------------
// AES-128 package
// Shared constants, types and byte-level functions of the AES-128 cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned REG_WIDTH  = 64;

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } t_reg_index;

    typedef logic [127:0] t_block;
    typedef logic [3:0]   t_round;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    function automatic logic [7:0] times_x(input logic [7:0] b);
        times_x = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte k of a block sits at bits 127-8k down to 120-8k.
    function automatic logic [7:0] get_byte(input t_block s, input int unsigned k);
        get_byte = s[127 - 8 * k -: 8];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Next round key from the current one, FIPS-197 schedule.
    function automatic t_block next_round_key(input t_block k, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        next_round_key = {w0, w1, w2, w3};
    endfunction

    function automatic t_block sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] = SBOX[get_byte(s, 4 * ((c + r) % 4) + r)];
            end
        end
        sub_shift = t;
    endfunction

    function automatic t_block mix_columns(input t_block s);
        t_block t;
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4 * c);
            a1  = get_byte(s, 4 * c + 1);
            a2  = get_byte(s, 4 * c + 2);
            a3  = get_byte(s, 4 * c + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 8 * (4 * c) -: 8]     = a0 ^ all ^ times_x(a0 ^ a1);
            t[127 - 8 * (4 * c + 1) -: 8] = a1 ^ all ^ times_x(a1 ^ a2);
            t[127 - 8 * (4 * c + 2) -: 8] = a2 ^ all ^ times_x(a2 ^ a3);
            t[127 - 8 * (4 * c + 3) -: 8] = a3 ^ all ^ times_x(a3 ^ a0);
        end
        mix_columns = t;
    endfunction

endpackage

/* sv/aes_block_if.sv */
// ----------------------------------------------------------------------------
// AES block channel
// Valid/ready channel that carries one 128-bit block as two 64-bit halves.
// ----------------------------------------------------------------------------
interface aes_block_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;

    modport source (output valid, output data_high, output data_low, input ready);
    modport sink (input valid, input data_high, input data_low, output ready);
endinterface

/* sv/aes_round_cell.sv */
// ----------------------------------------------------------------------------
// AES round cell
// One cipher round: registers the state, its round key and a valid bit, and
// derives the next round key so the key travels with the block.
// ----------------------------------------------------------------------------
module aes_round_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  logic            i_valid,
    input  aes_pkg::t_block i_state,
    input  aes_pkg::t_block i_key,
    input  logic [7:0]      i_rcon,
    input  logic            i_last,
    output logic            o_valid,
    output aes_pkg::t_block o_state,
    output aes_pkg::t_block o_key
);
    import aes_pkg::*;

    t_block r_state, n_state;
    t_block r_key, n_key;
    logic   r_valid;
    t_block sb;

    always_comb begin
        n_key   = next_round_key(i_key, i_rcon);
        sb      = sub_shift(i_state);
        n_state = (i_last ? sb : mix_columns(sb)) ^ n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;
endmodule

/* sv/aes128_block_encrypt.sv */
// ----------------------------------------------------------------------------
// AES-128 block encryption
// Ten round cells in a row; each beat's round keys are derived alongside it.
// ----------------------------------------------------------------------------
// A beat is registered in stage zero and then in each round cell on its way to the output.
// Throughput: one block per cycle; the row stalls only while the output is held.
// The key registers reset to zero, which gives the all-zero cipher key.
// Reset clears all valid bits; block data registers are not reset.
module aes128_block_encrypt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_index,
    input  logic [aes_pkg::REG_WIDTH-1:0]  i_cfg_data,
    aes_block_if.sink                      s_in,
    aes_block_if.source                    m_out
);
    import aes_pkg::*;

    logic   r_key_valid;
    t_block r_key;
    t_block r_state;
    t_block r_key0;
    logic   advance;

    logic   valid_c [NUM_ROUNDS+1];
    t_block state_c [NUM_ROUNDS+1];
    t_block key_c   [NUM_ROUNDS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_KEY_HIGH: r_key[127:64] <= i_cfg_data;
                REG_KEY_LOW:  r_key[63:0]   <= i_cfg_data;
                default:      r_key         <= r_key;
            endcase
        end
    end

    // The whole row moves when the last stage is empty or being taken.
    assign advance    = !m_out.valid || m_out.ready;
    assign s_in.ready = advance;

    // Stage zero holds the whitened block together with its cipher key.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_valid <= 1'b0;
        end else if (advance) begin
            r_key_valid <= s_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_state <= {s_in.data_high, s_in.data_low} ^ r_key;
            r_key0  <= r_key;
        end
    end

    assign valid_c[0] = r_key_valid;
    assign state_c[0] = r_state;
    assign key_c[0]   = r_key0;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        aes_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_advance (advance),
            .i_valid (valid_c[g]),
            .i_state (state_c[g]),
            .i_key   (key_c[g]),
            .i_rcon  (RCON[g]),
            .i_last  (g == NUM_ROUNDS - 1),
            .o_valid (valid_c[g+1]),
            .o_state (state_c[g+1]),
            .o_key   (key_c[g+1])
        );
    end

    assign m_out.valid     = valid_c[NUM_ROUNDS];
    assign m_out.data_high = state_c[NUM_ROUNDS][127:64];
    assign m_out.data_low  = state_c[NUM_ROUNDS][63:0];
endmodule
